>>> sv/dec_piles_pkg.sv
// ----------------------------------------------------------------------------
// dec_piles_pkg
// Shared constants and the item token type that moves along the pile chain.
// ----------------------------------------------------------------------------
package dec_piles_pkg;

	localparam int MAX_PILES = 256;
	localparam int VALUE_W   = 32;
	localparam int IDX_W     = $clog2(MAX_PILES);
	localparam int CNT_W     = $clog2(MAX_PILES + 1);
	localparam int PORT_IDX_W = 8;
	localparam int PORT_CNT_W = 9;

	typedef struct packed {
		logic               vld;
		logic [VALUE_W-1:0] value;
		logic               clear;
		logic               placed;
		logic               opened;
		logic [IDX_W-1:0]   idx;
		logic [CNT_W-1:0]   count;
	} token_t;

endpackage

>>> sv/decreasing_subsequence_piles_top.sv
// ----------------------------------------------------------------------------
// decreasing_subsequence_piles_top
// Greedy patience piling of a signed value stream into non-increasing piles.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the output does not stall and
// presents its results in order, once an item has passed the register of
// every pile cell and the output register. Each item walks the chain of pile
// cells one cell per cycle, lands on the first cell whose top is at least its
// value or that is not yet open, and counts the open piles on its way; a
// start request clears each cell as it passes. A stall at the output freezes
// the whole chain.
module decreasing_subsequence_piles_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [dec_piles_pkg::VALUE_W-1:0] value,
	input  logic                                  start_req,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dec_piles_pkg::PORT_IDX_W-1:0]  pile_index,
	output logic                                  new_pile,
	output logic [dec_piles_pkg::PORT_CNT_W-1:0]  pile_count,
	output logic                                  overflow
);
	import dec_piles_pkg::*;

	token_t chain [MAX_PILES+1];
	logic   adv;
	logic   out_valid_q;
	logic [PORT_IDX_W-1:0] pile_index_q;
	logic                  new_pile_q;
	logic [PORT_CNT_W-1:0] pile_count_q;
	logic                  overflow_q;

	assign adv      = ~out_valid_q | ~out_stall;
	assign in_stall = ~adv;

	assign chain[0] = {in_valid, value, start_req, 1'b0, 1'b0,
		{IDX_W{1'b0}}, {CNT_W{1'b0}}};

	for (genvar i = 0; i < MAX_PILES; i++) begin : g_cell
		dec_piles_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cell_idx (IDX_W'(i)),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[MAX_PILES].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && chain[MAX_PILES].vld) begin
			pile_index_q <= PORT_IDX_W'(chain[MAX_PILES].idx);
			new_pile_q   <= chain[MAX_PILES].opened;
			pile_count_q <= PORT_CNT_W'(chain[MAX_PILES].count);
			overflow_q   <= ~chain[MAX_PILES].placed;
		end
	end

	assign out_valid  = out_valid_q;
	assign pile_index = pile_index_q;
	assign new_pile   = new_pile_q;
	assign pile_count = pile_count_q;
	assign overflow   = overflow_q;

	// A dropped item never opens a pile.
	a_overflow_not_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(overflow && new_pile))
		else $error("overflow and new_pile both set");

	// A new pile is always the rightmost one.
	a_new_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_pile |-> pile_count == PORT_CNT_W'(pile_index) + 1'b1)
		else $error("new pile is not the last pile");

	// A placed item lands on an open pile.
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !overflow |-> PORT_CNT_W'(pile_index) < pile_count)
		else $error("pile index beyond pile count");

	// A held result holds the chain.
	a_stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while the result is held");

endmodule

>>> sv/dec_piles_cell.sv
// ----------------------------------------------------------------------------
// dec_piles_cell
// One pile of the chain: holds the pile top and its open flag, places a
// passing item when it qualifies, and hands the item token to the next cell.
// ----------------------------------------------------------------------------
module dec_piles_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic [dec_piles_pkg::IDX_W-1:0]     cell_idx,
	input  dec_piles_pkg::token_t               tok_in,
	output dec_piles_pkg::token_t               tok_out
);
	import dec_piles_pkg::*;

	logic               open_q;
	logic [VALUE_W-1:0] top_q;
	token_t             tok_s1;
	token_t             tok_next;
	logic               open_eff;
	logic               take;

	assign open_eff = open_q & ~tok_in.clear;
	assign take = tok_in.vld & ~tok_in.placed &
		(~open_eff | ($signed(top_q) >= $signed(tok_in.value)));

	always_comb begin
		tok_next = tok_in;
		tok_next.placed = tok_in.placed | take;
		if (take) begin
			tok_next.idx    = cell_idx;
			tok_next.opened = ~open_eff;
		end
		tok_next.count = tok_in.count + CNT_W'(open_eff | take);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			tok_s1 <= '0;
		end else if (adv) begin
			tok_s1 <= tok_next;
			if (take) begin
				open_q <= 1'b1;
			end else if (tok_in.vld && tok_in.clear) begin
				open_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			top_q <= tok_in.value;
		end
	end

	assign tok_out = tok_s1;

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the patience pile assigner.
// It feeds signed values through the valid and stall handshake and predicts
// pile placement, new piles, pile count and overflow for every item. It
// compares each result in order with that prediction. The stimulus covers
// the extremes, equal tops and restarts, and it fills all piles so that values
// are dropped. Both sides idle at random, and the receiver holds off once for
// a long time so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
	import dec_piles_pkg::*;

	typedef struct packed {
		logic [PORT_IDX_W-1:0] idx;
		logic                  new_pile;
		logic [PORT_CNT_W-1:0] count;
		logic                  overflow;
	} placement_t;

	typedef enum int {
		MIX_FULL,
		MIX_NARROW,
		MIX_EXTREME
	} value_mix_t;

	class pile_scoreboard_t;
		logic signed [VALUE_W-1:0] tops [MAX_PILES];
		int unsigned used = 0;
		placement_t placement_q[$];
		int errors = 0;
		int n_checked = 0;
		int n_opened = 0;
		int n_dropped = 0;
		int unsigned max_used = 0;

		function void place_value(logic signed [VALUE_W-1:0] v, logic restart);
			placement_t r;
			int slot;
			r = '0;
			slot = -1;
			if (restart)
				used = 0;
			for (int i = 0; i < used; i++)
				if (slot < 0 && tops[i] >= v)
					slot = i;
			if (slot >= 0) begin
				tops[slot] = v;
				r.idx = PORT_IDX_W'(slot);
			end else if (used < MAX_PILES) begin
				tops[used] = v;
				r.idx = PORT_IDX_W'(used);
				r.new_pile = 1'b1;
				used++;
				n_opened++;
			end else begin
				r.overflow = 1'b1;
				n_dropped++;
			end
			r.count = PORT_CNT_W'(used);
			if (used > max_used)
				max_used = used;
			placement_q = {placement_q, r};
		endfunction

		function void check_placement(logic [PORT_IDX_W-1:0] idx, logic opened,
				logic [PORT_CNT_W-1:0] count, logic dropped);
			placement_t want;
			if (placement_q.size() == 0) begin
				if (errors < 50)
					$display({"%0t: unexpected result: index %0d new %0b count %0d",
						" overflow %0b"}, $time, idx, opened, count, dropped);
				errors++;
				return;
			end
			want = placement_q.pop_front();
			n_checked++;
			if (idx !== want.idx || opened !== want.new_pile || count !== want.count ||
					dropped !== want.overflow) begin
				if (errors < 50)
					$display({"%0t: expected index %0d new %0b count %0d overflow %0b,",
						" actual index %0d new %0b count %0d overflow %0b"},
						$time, want.idx, want.new_pile, want.count, want.overflow,
						idx, opened, count, dropped);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic signed [VALUE_W-1:0]   value;
	logic                        start_req;
	logic                        out_valid;
	logic                        out_stall;
	logic [PORT_IDX_W-1:0]       pile_index;
	logic                        new_pile;
	logic [PORT_CNT_W-1:0]       pile_count;
	logic                        overflow;

	pile_scoreboard_t sb = new;
	bit tx_quiet = 1'b0;
	int n_sent = 0;

	decreasing_subsequence_piles_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.start_req  (start_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pile_index (pile_index),
		.new_pile   (new_pile),
		.pile_count (pile_count),
		.overflow   (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#600000;
		$display("decreasing_subsequence_piles_top: mismatch");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] draw_value(value_mix_t mix);
		logic [VALUE_W-1:0] pick;
		case (mix)
			MIX_NARROW: pick = $urandom_range(0, 16) - 8;
			MIX_EXTREME: begin
				case ($urandom_range(0, 5))
					0: pick = 32'h8000_0000;
					1: pick = 32'h8000_0001;
					2: pick = 32'h7FFF_FFFF;
					3: pick = 32'h7FFF_FFFE;
					4: pick = 32'hFFFF_FFFF;
					default: pick = '0;
				endcase
			end
			default: pick = $urandom;
		endcase
		return pick;
	endfunction

	task automatic send_item(input logic [VALUE_W-1:0] v, input logic restart);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		start_req <= restart;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.place_value(v, restart);
		n_sent++;
	endtask

	// A strictly increasing run opens every pile, so the values after it
	// that are above the last top are dropped.
	task automatic fill_piles();
		logic [VALUE_W-1:0] v;
		tx_quiet = ($urandom_range(0, 1) == 0);
		for (int i = 0; i < MAX_PILES; i++) begin
			v = {8'(i), 24'($urandom_range(0, 24'hFF_FFFE))} ^ 32'h8000_0000;
			send_item(v, i == 0);
		end
		send_item(32'h7FFF_FFFF, 1'b0);
		for (int i = 0; i < 8; i++)
			send_item(draw_value(value_mix_t'($urandom_range(0, 2))), 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
	endtask

	task automatic random_sequence();
		value_mix_t mix;
		int len;
		mix = value_mix_t'($urandom_range(0, 2));
		len = $urandom_range(1, 40);
		tx_quiet = ($urandom_range(0, 4) == 0);
		for (int k = 0; k < len; k++)
			send_item(draw_value(mix), k == 0 || $urandom_range(0, 29) == 0);
	endtask

	initial begin
		int w;
		bit held;
		bit rx_quiet;
		held = 1'b0;
		rx_quiet = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && sb.n_checked >= 300) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				held = 1'b1;
			end
			if (sb.n_checked % 97 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			w = rx_quiet ? 0 : $urandom_range(0, 9);
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			sb.check_placement(pile_index, new_pile, pile_count, overflow);
		end
	end

	initial begin
		int guard;
		bit refilled;
		refilled = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		start_req = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Right after reset a value opens pile 0 even without a start request.
		send_item(32'h0000_0000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h0000_0005, 1'b0);
		send_item(32'h0000_0006, 1'b0);
		send_item(32'h8000_0000, 1'b1);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h8000_0001, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h7FFF_FFFE, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b1);
		send_item(32'h8000_0000, 1'b1);
		send_item(32'h5555_5555, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b0);

		fill_piles();
		while (n_sent < 1850) begin
			if (!refilled && n_sent > 1100) begin
				fill_piles();
				refilled = 1'b1;
			end
			random_sequence();
		end
		in_valid <= 1'b0;

		guard = 0;
		while (sb.placement_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (400) @(posedge clk);
		if (sb.placement_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.placement_q.size());
			sb.errors++;
		end

		$display("Placed %0d values and checked %0d results;", n_sent, sb.n_checked);
		$display("%0d piles opened, %0d values dropped, at most %0d open, %0d failures.",
			sb.n_opened, sb.n_dropped, sb.max_used, sb.errors);
		if (sb.errors == 0)
			$display("decreasing_subsequence_piles_top: match");
		else
			$display("decreasing_subsequence_piles_top: mismatch");
		$finish;
	end

endmodule

>>> sim.f
sv/dec_piles_pkg.sv
sv/dec_piles_cell.sv
sv/decreasing_subsequence_piles_top.sv
dv/tb.sv
